// ----- design/utf8_latin1_repair_core_defines.svh -----
// Assertion helpers for the UTF-8 repair block.
`ifndef UTF8_LATIN1_REPAIR_CORE_DEFINES_SVH
`define UTF8_LATIN1_REPAIR_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ULR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ULR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ulr_pkg.sv -----
package ulr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WorkDepth = 4;
  localparam int unsigned LenW = 3;

  localparam logic [ByteW-1:0] TopBit    = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContPat   = 8'h80;
  localparam logic [ByteW-1:0] LowMask   = 8'h3F;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;
  } out_req_t;

  typedef enum logic [1:0] {
    ACT_PASS,
    ACT_SEQ,
    ACT_HOLD,
    ACT_CONV
  } act_e;

  typedef struct packed {
    act_e       act;
    logic [1:0] cont_cnt;
  } scan_res_t;

endpackage

// ----- design/ulr_scan.sv -----
module ulr_scan (
  input  logic [ulr_pkg::WorkDepth-1:0][ulr_pkg::ByteW-1:0] work_i,
  input  logic [ulr_pkg::LenW-1:0]                          len_i,
  input  logic                                              last_i,
  output ulr_pkg::scan_res_t                                res_o
);
  import ulr_pkg::*;

  logic [ByteW-1:0] lead;
  logic [LenW-1:0]  need;
  logic [LenW-1:0]  avail;
  logic             broken;

  assign lead = work_i[0];

  always_comb begin
    if ((lead & Lead2Mask) == Lead2Pat) begin
      need = 3'd2;
    end else if ((lead & Lead3Mask) == Lead3Pat) begin
      need = 3'd3;
    end else if ((lead & Lead4Mask) == Lead4Pat) begin
      need = 3'd4;
    end else begin
      need = 3'd0;
    end
  end

  assign avail = (len_i < need) ? len_i : need;

  // any byte inside the available window that is not a continuation
  always_comb begin
    broken = 1'b0;
    for (int i = 1; i < WorkDepth; i++) begin
      if ((LenW'(i) < avail) && ((work_i[i] & ContMask) != ContPat)) begin
        broken = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.cont_cnt = 2'(need - 3'd1);
    if ((lead & TopBit) == '0) begin
      res_o.act = ACT_PASS;
    end else if ((need == '0) || broken) begin
      res_o.act = ACT_CONV;
    end else if (avail < need) begin
      res_o.act = last_i ? ACT_CONV : ACT_HOLD;
    end else begin
      res_o.act = ACT_SEQ;
    end
  end

endmodule

// ----- design/ulr_out_stage.sv -----
module ulr_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ulr_pkg::out_req_t push_req_i,
  output logic              push_ready_o,
  output logic              out_valid_o,
  output ulr_pkg::out_req_t out_req_o,
  input  logic              out_stall_i
);
  import ulr_pkg::*;

  logic     valid_q, valid_d;
  out_req_t req_q;

  assign push_ready_o = !valid_q || !out_stall_i;
  assign valid_d      = push_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && push_ready_o) begin
      req_q <= push_req_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = req_q;

endmodule

// ----- design/utf8_latin1_repair_core.sv -----
// channel | dir | handshake          | payload
// in      | in  | in_valid_i/_stall_o  | in_req_i  (in_byte, string_end)
// out     | out | out_valid_o/_stall_i | out_req_o (out_byte, run_last, text_done)
// One request yields N output bytes (N = 0..8): after the accept, the scan, low and copy
// steps each emit one byte when the hold register can pass it on, then a closing scan and
// a flush end the run. A shared classifier looks at the head of the work buffer once per cycle.
// Each emitted byte waits in a hold register until the next one or the flush.
// Reset empties the pending store and the output register.
// A stalled output only pauses the sequencer; in_stall_o is high while busy.
`include "utf8_latin1_repair_core_defines.svh"

module utf8_latin1_repair_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ulr_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ulr_pkg::out_req_t out_req_o
);
  import ulr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOW,
    ST_COPY,
    ST_FLUSH
  } state_e;

  state_e                              state_q, state_d;
  logic [WorkDepth-1:0][ByteW-1:0]     work_q, work_d;
  logic [LenW-1:0]                     len_q, len_d;
  logic                                last_q, last_d;
  logic [1:0]                          cnt_q, cnt_d;
  logic                                hold_valid_q, hold_valid_d;
  logic [ByteW-1:0]                    hold_byte_q, hold_byte_d;

  scan_res_t scan_res;
  logic      push, push_ready, in_accept;
  out_req_t  push_req;
  logic      emit;
  logic [ByteW-1:0] emit_byte;
  logic      shift;

  ulr_scan u_scan (
    .work_i (work_q),
    .len_i  (len_q),
    .last_i (last_q),
    .res_o  (scan_res)
  );

  ulr_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_req_i   (push_req),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_req_o    (out_req_o),
    .out_stall_i  (out_stall_i)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    work_d       = work_q;
    len_d        = len_q;
    last_d       = last_q;
    cnt_d        = cnt_q;
    hold_valid_d = hold_valid_q;
    hold_byte_d  = hold_byte_q;
    push         = 1'b0;
    push_req     = '{out_byte: hold_byte_q, run_last: 1'b0, text_done: 1'b0};
    emit         = 1'b0;
    emit_byte    = work_q[0];
    shift        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          work_d[len_q[1:0]] = in_req_i.in_byte;
          len_d              = len_q + 3'd1;
          last_d             = in_req_i.string_end;
          state_d            = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (len_q == '0) begin
          state_d = ST_FLUSH;
        end else begin
          unique case (scan_res.act)
            ACT_PASS: begin
              emit  = 1'b1;
              shift = !hold_valid_q || push_ready;
            end
            ACT_SEQ: begin
              emit = 1'b1;
              if (!hold_valid_q || push_ready) begin
                shift   = 1'b1;
                cnt_d   = scan_res.cont_cnt;
                state_d = ST_COPY;
              end
            end
            ACT_CONV: begin
              emit      = 1'b1;
              emit_byte = Lead2Pat | {6'b0, work_q[0][7:6]};
              if (!hold_valid_q || push_ready) begin
                state_d = ST_LOW;
              end
            end
            ACT_HOLD: begin
              state_d = ST_FLUSH;
            end
            default: state_d = ST_FLUSH;
          endcase
        end
      end
      ST_LOW: begin
        emit      = 1'b1;
        emit_byte = ContPat | (work_q[0] & LowMask);
        if (!hold_valid_q || push_ready) begin
          shift   = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_COPY: begin
        emit = 1'b1;
        if (!hold_valid_q || push_ready) begin
          shift = 1'b1;
          cnt_d = cnt_q - 2'd1;
          if (cnt_q == 2'd1) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_FLUSH: begin
        push_req = '{out_byte: hold_byte_q, run_last: 1'b1, text_done: last_q};
        if (!hold_valid_q || push_ready) begin
          push         = hold_valid_q;
          hold_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit && (!hold_valid_q || push_ready)) begin
      push         = hold_valid_q;
      hold_valid_d = 1'b1;
      hold_byte_d  = emit_byte;
    end

    // consumed head byte leaves the work buffer
    if (shift) begin
      for (int i = 0; i < WorkDepth - 1; i++) begin
        work_d[i] = work_q[i+1];
      end
      len_d = len_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      len_q        <= '0;
      last_q       <= 1'b0;
      cnt_q        <= '0;
      hold_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      last_q       <= last_d;
      cnt_q        <= cnt_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q      <= work_d;
    hold_byte_q <= hold_byte_d;
  end

  `ULR_ASSERT_IMP(a_idle_room, state_q == ST_IDLE, len_q <= 3'd3, "pending store overfull")
  `ULR_ASSERT_IMP(a_push_room, push, push_ready, "push into a full output register")
  `ULR_ASSERT_IMP(a_end_empty, (state_q == ST_FLUSH) && last_q, len_q == '0,
                  "bytes left pending at end of string")
  `ULR_ASSERT_IMP(a_copy_cnt, state_q == ST_COPY, cnt_q != '0, "copy with zero count")
  `ULR_ASSERT_NXT(a_accept_busy, in_accept, in_stall_o, "not busy after accept")
  `ULR_ASSERT_IMP(a_idle_hold, state_q == ST_IDLE, !hold_valid_q, "held byte left at idle")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import ulr_pkg::*;

  localparam int CycLimit = 200000;
  localparam int RandItems = 220;
  localparam int NumRows = 27;

  // one directed row; bytes[0] is the first expected output byte
  typedef struct packed {
    logic [7:0]      b;
    logic            str_end;
    logic            typed;
    logic [3:0]      n;
    logic [0:7][7:0] bytes;
  } stim_row_t;

  // typed = 0: expectation comes from the predictor
  localparam stim_row_t DirRows [NumRows] = '{
    '{8'h41, 1'b0, 1'b1, 4'd1, 64'h4100_0000_0000_0000},  // ascii after reset
    '{8'h00, 1'b0, 1'b1, 4'd1, 64'h0000_0000_0000_0000},  // zero byte passes
    '{8'hFF, 1'b0, 1'b1, 4'd2, 64'hC3BF_0000_0000_0000},  // top latin-1
    '{8'h80, 1'b0, 1'b1, 4'd2, 64'hC280_0000_0000_0000},  // lone continuation
    '{8'hC3, 1'b0, 1'b1, 4'd0, 64'h0},                    // held
    '{8'hA9, 1'b0, 1'b1, 4'd2, 64'hC3A9_0000_0000_0000},
    '{8'hE2, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h82, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'hAC, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'hF0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h9F, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h98, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h80, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'hC3, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h41, 1'b0, 1'b1, 4'd3, 64'hC383_4100_0000_0000},  // broken pair
    '{8'hE2, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h82, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h41, 1'b0, 1'b0, 4'd0, 64'h0},                    // broken, rescan
    '{8'hE2, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'hAC, 1'b1, 1'b0, 4'd0, 64'h0},                    // short at string end
    '{8'hF8, 1'b1, 1'b1, 4'd2, 64'hC3B8_0000_0000_0000},
    '{8'hF0, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h9F, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h98, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'hF0, 1'b1, 1'b0, 4'd0, 64'h0},                    // eight outputs
    '{8'hC3, 1'b0, 1'b0, 4'd0, 64'h0},
    '{8'h00, 1'b1, 1'b1, 4'd3, 64'hC383_0000_0000_0000}   // zero after lead
  };

  logic     clk_i;
  logic     rst_ni;
  logic     src_valid;
  logic     in_stall_o;
  in_req_t  src_req;
  logic     out_valid_o;
  logic     snk_stall;
  out_req_t out_req_o;

  int send_idle_pct;
  int recv_stall_pct;
  int err_cnt;
  int cyc_cnt;

  // predictor state
  logic [7:0] held_bytes [3];
  logic [1:0] held_cnt;
  out_req_t   fix_res [8];
  int         fix_cnt;

  out_req_t   repaired_q [$];

  utf8_latin1_repair_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (src_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (src_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (snk_stall),
    .out_req_o   (out_req_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_err(input string what);
    $display("tb: mismatch at cycle %0d: %s", cyc_cnt, what);
    err_cnt++;
  endtask

  function automatic int lead_len(input logic [7:0] b);
    if ((b & Lead2Mask) == Lead2Pat) return 2;
    if ((b & Lead3Mask) == Lead3Pat) return 3;
    if ((b & Lead4Mask) == Lead4Pat) return 4;
    return 0;
  endfunction

  function automatic void emit(input logic [7:0] b);
    if (fix_cnt < 8) begin
      fix_res[fix_cnt] = '{out_byte: b, run_last: 1'b0, text_done: 1'b0};
      fix_cnt++;
    end
  endfunction

  // repairs one source byte against the held bytes, fills fix_res
  function automatic void repair_byte(input logic [7:0] b, input logic last);
    logic [7:0] work [4];
    int len, pos, need, avail;
    logic bad;
    fix_cnt = 0;
    len = held_cnt;
    for (int i = 0; i < len; i++) work[i] = held_bytes[i];
    work[len] = b;
    len++;
    pos = 0;
    while (pos < len) begin
      if (!work[pos][7]) begin
        emit(work[pos]);
        pos++;
      end else begin
        need = lead_len(work[pos]);
        bad = (need == 0);
        if (!bad) begin
          avail = len - pos;
          if (avail > need) avail = need;
          for (int i = 1; i < avail; i++)
            if ((work[pos+i] & ContMask) != ContPat) bad = 1'b1;
          if (!bad && avail < need) begin
            if (last) bad = 1'b1;
            else break;
          end
        end
        if (bad) begin
          emit(Lead2Pat | (work[pos] >> 6));
          emit(ContPat | (work[pos] & LowMask));
          pos++;
        end else begin
          for (int i = 0; i < need; i++) emit(work[pos+i]);
          pos += need;
        end
      end
    end
    held_cnt = 2'(len - pos);
    for (int i = 0; i < held_cnt; i++) held_bytes[i] = work[pos+i];
    if (fix_cnt > 0) begin
      fix_res[fix_cnt-1].run_last = 1'b1;
      fix_res[fix_cnt-1].text_done = last;
    end
  endfunction

  function automatic logic [7:0] make_lead(input int n);
    case (n)
      2: return Lead2Pat | 8'($urandom_range(0, 31));
      3: return Lead3Pat | 8'($urandom_range(0, 15));
      default: return Lead4Pat | 8'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_item(input in_req_t r);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      src_valid <= 1'b0;
      @(negedge clk_i);
    end
    src_req   <= r;
    src_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    repair_byte(r.in_byte, r.string_end);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) snk_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && out_valid_o && !snk_stall) begin
      if (repaired_q.size() == 0) begin
        report_err($sformatf("unexpected byte %h", out_req_o.out_byte));
      end else begin
        want = repaired_q.pop_front();
        if (out_req_o.out_byte !== want.out_byte)
          report_err($sformatf("out_byte %h, want %h", out_req_o.out_byte, want.out_byte));
        if (out_req_o.run_last !== want.run_last)
          report_err($sformatf("run_last %b, want %b", out_req_o.run_last, want.run_last));
        if (out_req_o.text_done !== want.text_done)
          report_err($sformatf("text_done %b, want %b", out_req_o.text_done, want.text_done));
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt == CycLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_req_t   rand_q [$];
    in_req_t   r;
    stim_row_t row;
    int        toks, kind, n, cut, start;
    rst_ni = 1'b0;
    src_valid = 1'b0;
    src_req = '0;
    snk_stall = 1'b0;
    err_cnt = 0;
    cyc_cnt = 0;
    held_cnt = '0;
    for (int i = 0; i < 3; i++) held_bytes[i] = '0;
    send_idle_pct = 38;
    recv_stall_pct = 57;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      row = DirRows[i];
      send_item('{in_byte: row.b, string_end: row.str_end});
      if (row.typed) begin
        for (int k = 0; k < row.n; k++)
          repaired_q.push_back('{out_byte: row.bytes[k], run_last: (k == row.n - 1),
                                 text_done: (k == row.n - 1) && row.str_end});
      end else begin
        for (int k = 0; k < fix_cnt; k++) repaired_q.push_back(fix_res[k]);
      end
    end

    // random strings: ascii, well-formed sequences, some latin-1, truncation and noise
    while (rand_q.size() < RandItems) begin
      toks = $urandom_range(1, 12);
      start = rand_q.size();
      for (int t = 0; t < toks; t++) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          rand_q.push_back('{in_byte: 8'($urandom_range(1, 127)), string_end: 1'b0});
        end else if (kind < 65 || kind >= 80 && kind < 92) begin
          n = $urandom_range(2, 4);
          cut = (kind < 65) ? n - 1 : $urandom_range(0, n - 2);
          rand_q.push_back('{in_byte: make_lead(n), string_end: 1'b0});
          for (int c = 0; c < cut; c++)
            rand_q.push_back('{in_byte: ContPat | 8'($urandom_range(0, 63)),
                               string_end: 1'b0});
        end else if (kind < 80) begin
          rand_q.push_back('{in_byte: 8'($urandom_range(128, 255)), string_end: 1'b0});
        end else begin
          rand_q.push_back('{in_byte: 8'($urandom_range(1, 255)), string_end: 1'b0});
        end
      end
      if (rand_q.size() > start) rand_q[rand_q.size()-1].string_end = 1'b1;
    end

    for (int i = 0; i < rand_q.size(); i++) begin
      if (i == rand_q.size() / 3) begin
        send_idle_pct = 57;
        recv_stall_pct = 38;
      end else if (i == 2 * rand_q.size() / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      r = rand_q[i];
      send_item(r);
      for (int k = 0; k < fix_cnt; k++) repaired_q.push_back(fix_res[k]);
    end

    @(negedge clk_i);
    src_valid <= 1'b0;
    while (repaired_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/ulr_pkg.sv
design/ulr_scan.sv
design/ulr_out_stage.sv
design/utf8_latin1_repair_core.sv
verif/tb_top.sv
